// File: design/tqcm_pkg.sv
// Shared types and constants for the three-queue channel mover.
// Holds the transaction payload structs and the queue codes.
// No dependencies.
`timescale 1ns / 1ps

package tqcm_pkg;

    // Default number of channels
    localparam int CHANNEL_COUNT_DEF = 16;

    // Queue codes carried in target_queue and in the membership store
    localparam logic [1:0] Q_FREE   = 2'd0;
    localparam logic [1:0] Q_IDLE   = 2'd1;
    localparam logic [1:0] Q_BUSY   = 2'd2;
    localparam logic [1:0] Q_UNUSED = 2'd3;

    // Input transaction
    typedef struct packed {
        logic [3:0] channel_id;
        logic [1:0] target_queue;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic       moved;
        logic       contention;
        logic       busy_head_valid;
        logic [3:0] busy_head;
        logic       idle_head_valid;
        logic [3:0] idle_head;
        logic       free_head_valid;
        logic [3:0] free_head;
    } t_out;

endpackage

// File: design/tqcm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds its value while no read is issued.
// No dependencies.
`timescale 1ns / 1ps

module tqcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/three_queue_channel_mover.sv
// Three-queue channel mover: keeps every channel on one of three linked FIFO queues.
// Depends on tqcm_pkg (types, queue codes) and tqcm_ram (link and membership stores).
`timescale 1ns / 1ps

// Usage
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one transaction naming a
// channel and a target queue (free, idle, busy). Output channel (o_out_valid /
// i_out_stall / o_out_data) returns one result per input: moved flag, contention
// and the head of each queue with its valid flag.
// The successor links and queue membership live in two RAMs with registered read
// data; the head and tail of each queue are registers. A move reads the channel's
// entry, walks the link RAM one entry per cycle to find the predecessor unless the
// channel heads its queue, then writes the unlink and the append back, and finally
// reads the busy head's link for the contention flag.
// One transaction is in flight at a time; the next one is accepted once the result
// has been placed in the output register, even while that result is stalled.
// After reset the block runs an initialization pass that builds the free list in
// index order; o_in_stall stays high until it finishes.
// A stalled result holds in the output register; a following result waits for it.
module three_queue_channel_mover #(
    parameter int CHANNEL_COUNT = tqcm_pkg::CHANNEL_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tqcm_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tqcm_pkg::t_out o_out_data
);

    localparam int LW = $clog2(CHANNEL_COUNT + 1);  // link width, holds "none"
    localparam int CW = $clog2(CHANNEL_COUNT);      // channel index width
    localparam int EW = LW + 4;
    localparam logic [LW-1:0] NONE = LW'(CHANNEL_COUNT);
    localparam logic [LW-1:0] LAST = LW'(CHANNEL_COUNT - 1);

    typedef enum logic [8:0] {
        ST_INIT   = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_LOOK   = 9'b000000100,
        ST_WALK   = 9'b000001000,
        ST_UNLINK = 9'b000010000,
        ST_APP1   = 9'b000100000,
        ST_APP2   = 9'b001000000,
        ST_HEAD   = 9'b010000000,
        ST_DONE   = 9'b100000000
    } t_state;

    function automatic logic is_ch(input logic [LW-1:0] x);
        return x < NONE;
    endfunction

    t_state          r_state, n_state;
    logic [LW-1:0]   r_init;
    logic [LW-1:0]   r_first [3];
    logic [LW-1:0]   r_last  [3];
    logic [LW-1:0]   r_c, r_nxt, r_walk, r_prev, r_steps;
    logic [1:0]      r_tgt, r_cur;
    logic            r_moved;
    logic            r_out_valid;
    tqcm_pkg::t_out  r_out;

    // RAM ports
    logic            rd_en;
    logic [CW-1:0]   rd_addr;
    logic            lk_we, mq_we;
    logic [CW-1:0]   lk_waddr, mq_waddr;
    logic [LW-1:0]   lk_wdata, lk_rdata;
    logic [1:0]      mq_wdata, mq_rdata;

    logic [EW-1:0]   cid_ext;
    logic            in_acc, in_ok, out_free;
    logic [1:0]      cur_q;
    tqcm_pkg::t_out  res;
    logic [EW-1:0]   bh_ext, ih_ext, fh_ext;

    tqcm_ram #(.WIDTH(LW), .DEPTH(CHANNEL_COUNT)) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (lk_we),
        .i_waddr(lk_waddr),
        .i_wdata(lk_wdata),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(lk_rdata)
    );

    tqcm_ram #(.WIDTH(2), .DEPTH(CHANNEL_COUNT)) u_member_ram (
        .i_clk  (i_clk),
        .i_we   (mq_we),
        .i_waddr(mq_waddr),
        .i_wdata(mq_wdata),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(mq_rdata)
    );

    // Input decode
    assign cid_ext    = EW'(i_in_data.channel_id);
    assign in_ok      = (cid_ext < EW'(CHANNEL_COUNT)) &&
                        (i_in_data.target_queue != tqcm_pkg::Q_UNUSED);
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cur_q      = (mq_rdata == tqcm_pkg::Q_UNUSED) ? tqcm_pkg::Q_FREE : mq_rdata;

    // Result assembly; link read data holds the busy head's successor in ST_DONE
    assign bh_ext = EW'(r_first[tqcm_pkg::Q_BUSY]);
    assign ih_ext = EW'(r_first[tqcm_pkg::Q_IDLE]);
    assign fh_ext = EW'(r_first[tqcm_pkg::Q_FREE]);

    always_comb begin
        res.moved           = r_moved;
        res.contention      = is_ch(r_first[tqcm_pkg::Q_BUSY]) && is_ch(lk_rdata);
        res.busy_head_valid = is_ch(r_first[tqcm_pkg::Q_BUSY]);
        res.busy_head       = res.busy_head_valid ? bh_ext[3:0] : 4'd0;
        res.idle_head_valid = is_ch(r_first[tqcm_pkg::Q_IDLE]);
        res.idle_head       = res.idle_head_valid ? ih_ext[3:0] : 4'd0;
        res.free_head_valid = is_ch(r_first[tqcm_pkg::Q_FREE]);
        res.free_head       = res.free_head_valid ? fh_ext[3:0] : 4'd0;
    end

    // Sequencer: next state and RAM access per state
    always_comb begin
        n_state  = r_state;
        rd_en    = 1'b0;
        rd_addr  = '0;
        lk_we    = 1'b0;
        lk_waddr = r_c[CW-1:0];
        lk_wdata = NONE;
        mq_we    = 1'b0;
        mq_waddr = r_c[CW-1:0];
        mq_wdata = r_tgt;
        case (r_state)
            ST_INIT: begin
                // build the free list in index order
                lk_we    = 1'b1;
                lk_waddr = r_init[CW-1:0];
                lk_wdata = r_init + 1'b1;
                mq_we    = 1'b1;
                mq_waddr = r_init[CW-1:0];
                mq_wdata = tqcm_pkg::Q_FREE;
                if (r_init == LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_ok) begin
                        rd_en   = 1'b1;
                        rd_addr = cid_ext[CW-1:0];
                        n_state = ST_LOOK;
                    end else begin
                        n_state = ST_HEAD;
                    end
                end
            end
            ST_LOOK: begin
                // channel's own entry is on the read port
                if (cur_q == r_tgt) begin
                    n_state = ST_HEAD;
                end else if (r_first[cur_q] == r_c) begin
                    n_state = ST_APP1;
                end else if (is_ch(r_first[cur_q])) begin
                    rd_en   = 1'b1;
                    rd_addr = r_first[cur_q][CW-1:0];
                    n_state = ST_WALK;
                end else begin
                    n_state = ST_APP1;
                end
            end
            ST_WALK: begin
                // one link per cycle until the predecessor turns up or the list ends
                if (lk_rdata == r_c) begin
                    n_state = ST_UNLINK;
                end else if (r_steps != LAST && is_ch(lk_rdata)) begin
                    rd_en   = 1'b1;
                    rd_addr = lk_rdata[CW-1:0];
                end else begin
                    n_state = ST_APP1;
                end
            end
            ST_UNLINK: begin
                lk_we    = 1'b1;
                lk_waddr = r_prev[CW-1:0];
                lk_wdata = r_nxt;
                n_state  = ST_APP1;
            end
            ST_APP1: begin
                lk_we = 1'b1;
                mq_we = 1'b1;
                if (is_ch(r_first[r_tgt]) && is_ch(r_last[r_tgt])) begin
                    n_state = ST_APP2;
                end else begin
                    n_state = ST_HEAD;
                end
            end
            ST_APP2: begin
                // old tail now points at the moved channel
                lk_we    = 1'b1;
                lk_waddr = r_prev[CW-1:0];
                lk_wdata = r_c;
                n_state  = ST_HEAD;
            end
            ST_HEAD: begin
                if (is_ch(r_first[tqcm_pkg::Q_BUSY])) begin
                    rd_en   = 1'b1;
                    rd_addr = r_first[tqcm_pkg::Q_BUSY][CW-1:0];
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                     <= ST_INIT;
            r_init                      <= '0;
            r_out_valid                 <= 1'b0;
            r_first[tqcm_pkg::Q_FREE]   <= '0;
            r_last[tqcm_pkg::Q_FREE]    <= LAST;
            r_first[tqcm_pkg::Q_IDLE]   <= NONE;
            r_last[tqcm_pkg::Q_IDLE]    <= NONE;
            r_first[tqcm_pkg::Q_BUSY]   <= NONE;
            r_last[tqcm_pkg::Q_BUSY]    <= NONE;
        end else begin
            r_state <= n_state;
            // output register: load a finished result, drop one the receiver took
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_INIT: r_init <= r_init + 1'b1;
                ST_IDLE: begin
                    if (in_acc) begin
                        r_c     <= LW'(cid_ext);
                        r_tgt   <= i_in_data.target_queue;
                        r_moved <= 1'b0;
                    end
                end
                ST_LOOK: begin
                    r_cur   <= cur_q;
                    r_nxt   <= lk_rdata;
                    r_walk  <= r_first[cur_q];
                    r_steps <= '0;
                    // channel at the head: advance the head directly
                    if (cur_q != r_tgt && r_first[cur_q] == r_c) begin
                        r_first[cur_q] <= lk_rdata;
                        if (!is_ch(lk_rdata)) begin
                            r_last[cur_q] <= NONE;
                        end
                    end
                end
                ST_WALK: begin
                    if (lk_rdata == r_c) begin
                        r_prev <= r_walk;
                    end else begin
                        r_walk  <= lk_rdata;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                ST_UNLINK: begin
                    if (r_last[r_cur] == r_c) begin
                        r_last[r_cur] <= r_prev;
                    end
                end
                ST_APP1: begin
                    r_moved <= 1'b1;
                    if (!is_ch(r_first[r_tgt])) begin
                        r_first[r_tgt] <= r_c;
                    end else if (is_ch(r_last[r_tgt])) begin
                        r_prev <= r_last[r_tgt];
                    end
                    r_last[r_tgt] <= r_c;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out <= res;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A queue's head and tail are empty together
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_first[tqcm_pkg::Q_FREE] < NONE) == (r_last[tqcm_pkg::Q_FREE] < NONE)) &&
        ((r_first[tqcm_pkg::Q_IDLE] < NONE) == (r_last[tqcm_pkg::Q_IDLE] < NONE)) &&
        ((r_first[tqcm_pkg::Q_BUSY] < NONE) == (r_last[tqcm_pkg::Q_BUSY] < NONE)))
        else $error("queue head and tail disagree on empty");

    // Contention needs a non-empty busy queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.contention |-> o_out_data.busy_head_valid)
        else $error("contention without busy head");

    // A finished transaction lands in the output register and frees the input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && out_free |=> o_out_valid && !o_in_stall)
        else $error("result not delivered");

endmodule

// File: tb/sv/tb_three_queue_channel_mover.sv
// Self-checking testbench for three_queue_channel_mover: a directed run, then random traffic
// under several sender/receiver idle mixes, all checked against a behavioral queue model.
// Depends on tqcm_pkg and the three_queue_channel_mover RTL.
`timescale 1ns / 1ps

module tb_three_queue_channel_mover;

    localparam int         NUM_CH       = tqcm_pkg::CHANNEL_COUNT_DEF;
    localparam logic [4:0] NO_LINK      = 5'(NUM_CH);
    // no transaction for this long means the block hung; a move plus a long stall run
    // stays far below it
    localparam int         QUIET_LIMIT  = 4000;
    localparam int         DRAIN_CYCLES = NUM_CH + 12;
    // transactions per random phase
    localparam int         PHASE_ITEMS  = 411;

    logic           i_clk     = 1'b0;
    logic           i_rst_n   = 1'b0;
    logic           in_valid  = 1'b0;
    tqcm_pkg::t_in  in_data   = '0;
    logic           out_stall = 1'b0;
    logic           in_stall;
    logic           out_valid;
    tqcm_pkg::t_out out_data;

    // model of the queue state
    logic [4:0] chan_link  [NUM_CH];
    logic [1:0] chan_queue [NUM_CH];
    logic [4:0] queue_head [3];
    logic [4:0] queue_tail [3];

    tqcm_pkg::t_out expected_status_q [$];
    int   fail_count     = 0;
    int   item_count     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles   = 0;

    three_queue_channel_mover #(
        .CHANNEL_COUNT(NUM_CH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always #1 i_clk = ~i_clk;

    // all channels on the free queue in index order
    function automatic void reset_queues();
        for (int i = 0; i < NUM_CH; i++) begin
            chan_link[i]  = 5'(i + 1);
            chan_queue[i] = tqcm_pkg::Q_FREE;
        end
        chan_link[NUM_CH - 1]        = NO_LINK;
        queue_head[tqcm_pkg::Q_FREE] = 5'd0;
        queue_tail[tqcm_pkg::Q_FREE] = 5'(NUM_CH - 1);
        queue_head[tqcm_pkg::Q_IDLE] = NO_LINK;
        queue_tail[tqcm_pkg::Q_IDLE] = NO_LINK;
        queue_head[tqcm_pkg::Q_BUSY] = NO_LINK;
        queue_tail[tqcm_pkg::Q_BUSY] = NO_LINK;
    endfunction

    // {valid, head} as reported for one queue
    function automatic logic [4:0] head_of(logic [1:0] q);
        if (queue_head[q] < NUM_CH) begin
            return {1'b1, queue_head[q][3:0]};
        end
        return 5'd0;
    endfunction

    // apply one request to the model and return the status it reports
    function automatic tqcm_pkg::t_out apply_move(tqcm_pkg::t_in req);
        logic [3:0]     ch;
        logic [1:0]     src;
        logic [1:0]     dst;
        logic [4:0]     nxt;
        logic [4:0]     walk;
        logic [4:0]     prev;
        logic [4:0]     bh;
        tqcm_pkg::t_out res;
        ch  = req.channel_id;
        dst = req.target_queue;
        res = '0;
        if (ch < NUM_CH && dst != tqcm_pkg::Q_UNUSED) begin
            src = chan_queue[ch];
            if (src == tqcm_pkg::Q_UNUSED) begin
                src = tqcm_pkg::Q_FREE;
            end
            if (src != dst) begin
                // unlink: head case, else walk to the predecessor
                nxt = chan_link[ch];
                if (queue_head[src] == 5'(ch)) begin
                    queue_head[src] = nxt;
                    if (nxt == NO_LINK) begin
                        queue_tail[src] = NO_LINK;
                    end
                end else begin
                    prev = NO_LINK;
                    walk = queue_head[src];
                    for (int s = 0; s < NUM_CH && walk < NUM_CH && prev == NO_LINK; s++) begin
                        if (chan_link[walk] == 5'(ch)) begin
                            prev = walk;
                        end else begin
                            walk = chan_link[walk];
                        end
                    end
                    if (prev != NO_LINK) begin
                        chan_link[prev] = nxt;
                        if (queue_tail[src] == 5'(ch)) begin
                            queue_tail[src] = prev;
                        end
                    end
                end
                // append at the tail of the target queue
                chan_queue[ch] = dst;
                chan_link[ch]  = NO_LINK;
                if (queue_head[dst] == NO_LINK) begin
                    queue_head[dst] = 5'(ch);
                end else if (queue_tail[dst] != NO_LINK) begin
                    chan_link[queue_tail[dst]] = 5'(ch);
                end
                queue_tail[dst] = 5'(ch);
                res.moved = 1'b1;
            end
        end
        bh = queue_head[tqcm_pkg::Q_BUSY];
        if (bh < NUM_CH) begin
            res.contention = (chan_link[bh] < NUM_CH);
        end
        {res.busy_head_valid, res.busy_head} = head_of(tqcm_pkg::Q_BUSY);
        {res.idle_head_valid, res.idle_head} = head_of(tqcm_pkg::Q_IDLE);
        {res.free_head_valid, res.free_head} = head_of(tqcm_pkg::Q_FREE);
        return res;
    endfunction

    // send one transaction, with an optional idle gap before it
    task automatic send_request(input logic [3:0] ch, input logic [1:0] tq);
        tqcm_pkg::t_in  req;
        tqcm_pkg::t_out res;
        req.channel_id   = ch;
        req.target_queue = tq;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (in_stall);
        res = apply_move(req);
        expected_status_q.push_back(res);
        item_count++;
    endtask

    // hold off the sender until every outstanding result is back
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_status_q.size() != 0);
    endtask

    // result checker
    always @(posedge i_clk) begin
        tqcm_pkg::t_out exp_r;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_status_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
                fail_count++;
            end else begin
                exp_r = expected_status_q.pop_front();
                if (exp_r !== out_data) begin
                    $display("%0t: result mismatch, expected %h, actual %h",
                             $time, exp_r, out_data);
                    fail_count++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog: cycles without any transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // head, middle and tail unlinks, empty queues, same queue and the unused target code
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(4'd0,  tqcm_pkg::Q_UNUSED);  // ignored, heads from reset
        send_request(4'd5,  tqcm_pkg::Q_FREE);    // already there
        send_request(4'd0,  tqcm_pkg::Q_BUSY);    // head of free
        send_request(4'd15, tqcm_pkg::Q_BUSY);    // tail of free, contention starts
        send_request(4'd7,  tqcm_pkg::Q_BUSY);    // middle of free
        send_request(4'd15, tqcm_pkg::Q_IDLE);    // middle of busy
        send_request(4'd7,  tqcm_pkg::Q_IDLE);    // tail of busy
        send_request(4'd0,  tqcm_pkg::Q_FREE);    // busy empties
        send_request(4'd15, tqcm_pkg::Q_IDLE);    // already there
        send_request(4'd15, tqcm_pkg::Q_UNUSED);
        send_request(4'd10, tqcm_pkg::Q_IDLE);
        send_request(4'd15, tqcm_pkg::Q_FREE);    // head of idle
        send_request(4'd7,  tqcm_pkg::Q_BUSY);    // idle down to one
        send_request(4'd10, tqcm_pkg::Q_BUSY);
        send_request(4'd10, tqcm_pkg::Q_FREE);    // tail of busy, contention ends
        send_request(4'd7,  tqcm_pkg::Q_FREE);
    endtask

    // random single moves mixed with sweeps that pull every channel onto one queue
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int items);
        int         goal;
        int         order [NUM_CH];
        int         j;
        int         tmp;
        logic [1:0] tq;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        goal           = item_count + items;
        while (item_count < goal) begin
            if ($urandom_range(99) < 12) begin
                tq = 2'($urandom_range(2));
                for (int i = 0; i < NUM_CH; i++) begin
                    order[i] = i;
                end
                for (int i = NUM_CH - 1; i > 0; i--) begin
                    j        = $urandom_range(i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < NUM_CH; i++) begin
                    send_request(4'(order[i]), tq);
                end
            end else begin
                tq = ($urandom_range(19) == 0) ? tqcm_pkg::Q_UNUSED : 2'($urandom_range(2));
                send_request(4'($urandom_range(NUM_CH - 1)), tq);
            end
        end
    endtask

    initial begin
        reset_queues();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        pause_until_drained();
        test_random_traffic(29, 83, PHASE_ITEMS);
        pause_until_drained();
        test_random_traffic(83, 29, PHASE_ITEMS);
        pause_until_drained();
        test_random_traffic(0, 0, PHASE_ITEMS);
        pause_until_drained();
        // catch any stray result
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
design/tqcm_pkg.sv
design/tqcm_ram.sv
design/three_queue_channel_mover.sv
tb/sv/tb_three_queue_channel_mover.sv
